// File: design/blag_pkg.sv
// Package: widths, codes and types shared by the line address generator.
`default_nettype none

package blag_pkg;

  // Coordinate and derived widths
  localparam int COORD_BITS    = 11;
  localparam int DELTA_BITS    = COORD_BITS + 1;
  localparam int ERR_BITS      = COORD_BITS + 2;
  localparam int OFS_BITS      = 24;
  localparam int COLOR_BITS    = 24;
  localparam int WIDTH_BITS    = 12;
  localparam int STRIDE_BITS   = WIDTH_BITS + 2;
  localparam int PROD_BITS     = (STRIDE_BITS + COORD_BITS > OFS_BITS) ?
                                 (STRIDE_BITS + COORD_BITS) : OFS_BITS;
  localparam int GREY_BITS     = 8;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_FORMAT = 2'd1;

  localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 12'd640;

  // Request and format codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam logic FMT_GREY = 1'b0;
  localparam logic FMT_RGB  = 1'b1;

  // Line setup computed from a load beat
  typedef struct packed {
    logic signed [ERR_BITS-1:0] error_term;
    logic [DELTA_BITS-1:0]      major_delta;
    logic [DELTA_BITS-1:0]      minor_delta;
    logic [OFS_BITS-1:0]        start_offset;
    logic [OFS_BITS-1:0]        major_step;
    logic [OFS_BITS-1:0]        minor_step;
    logic [DELTA_BITS-1:0]      pixels_left;
    logic [COLOR_BITS-1:0]      line_color;
    logic                       line_active;
  } line_setup_t;

endpackage

`default_nettype wire

// File: design/blag_if.sv
// Interfaces: request, pixel and configuration channels.
`default_nettype none

interface blag_req_if;
  import blag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0] pixel_value;

  modport source (output valid, req_type, x_start, y_start, x_end, y_end, pixel_value,
                  input ready);
  modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, pixel_value,
                  output ready);
endinterface

interface blag_pix_if;
  import blag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OFS_BITS-1:0]   pixel_offset;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  modport source (output valid, pixel_offset, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_offset, pixel_color, last_pixel, output ready);
endinterface

interface blag_cfg_if;
  import blag_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/blag_setup.sv
// Line setup: major axis, deltas, error term, steps and start offset of a load.
`default_nettype none

module blag_setup
  import blag_pkg::*;
(
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  input  wire logic [COLOR_BITS-1:0] pixel_value,
  input  wire logic [WIDTH_BITS-1:0] image_width,
  input  wire logic                  pixel_format,
  output line_setup_t                setup
);

  logic [STRIDE_BITS-1:0] width_ext;
  logic [STRIDE_BITS-1:0] stride;
  logic [OFS_BITS-1:0]    stride_ofs;
  logic [OFS_BITS-1:0]    bpp_ofs;
  logic [OFS_BITS-1:0]    x_ofs;
  logic [OFS_BITS-1:0]    x_byte;
  logic [PROD_BITS-1:0]   row_prod;
  logic [OFS_BITS-1:0]    x_step;
  logic [OFS_BITS-1:0]    y_step;
  logic [COORD_BITS-1:0]  adx;
  logic [COORD_BITS-1:0]  ady;
  logic [DELTA_BITS-1:0]  major;
  logic [DELTA_BITS-1:0]  minor;
  logic [DELTA_BITS-1:0]  count;
  logic                   x_major;

  // Row stride in bytes
  assign width_ext  = {2'b00, image_width};
  assign stride     = (pixel_format == FMT_RGB) ? ((width_ext << 1) + width_ext) : width_ext;
  assign stride_ofs = {{(OFS_BITS-STRIDE_BITS){1'b0}}, stride};
  assign bpp_ofs    = (pixel_format == FMT_RGB) ? OFS_BITS'(3) : OFS_BITS'(1);

  // Start offset: bpp*x plus stride*y, wrapped to the offset width
  assign x_ofs    = {{(OFS_BITS-COORD_BITS){1'b0}}, x_start};
  assign x_byte   = (pixel_format == FMT_RGB) ? ((x_ofs << 1) + x_ofs) : x_ofs;
  assign row_prod = {{(PROD_BITS-STRIDE_BITS){1'b0}}, stride} *
                    {{(PROD_BITS-COORD_BITS){1'b0}}, y_start};

  // Signed byte steps per axis
  assign x_step = (x_end >= x_start) ? bpp_ofs : (OFS_BITS'(0) - bpp_ofs);
  assign y_step = (y_end >= y_start) ? stride_ofs : (OFS_BITS'(0) - stride_ofs);

  // Absolute differences and axis choice
  assign adx     = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
  assign ady     = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);
  assign x_major = (adx >= ady);
  assign count   = {1'b0, (x_major ? adx : ady)};
  assign major   = count + DELTA_BITS'(1);
  assign minor   = {1'b0, (x_major ? ady : adx)} + DELTA_BITS'(1);

  // Pack the setup
  always_comb begin
    setup.error_term   = $signed({1'b0, major} - {2'b00, minor[DELTA_BITS-1:1]});
    setup.major_delta  = major;
    setup.minor_delta  = minor;
    setup.start_offset = x_byte + row_prod[OFS_BITS-1:0];
    setup.major_step   = x_major ? x_step : y_step;
    setup.minor_step   = x_major ? y_step : x_step;
    setup.pixels_left  = count;
    setup.line_color   = (pixel_format == FMT_RGB) ? pixel_value :
                         {{(COLOR_BITS-GREY_BITS){1'b0}}, pixel_value[GREY_BITS-1:0]};
    setup.line_active  = (count != '0);
  end

endmodule

`default_nettype wire

// File: design/bresenham_line_address_generator.sv
// Top level: Bresenham line address generator with registered pixel output.
//
//   channel | dir | beat                                   | fires on
//   req     | in  | req_type, endpoints, pixel_value       | valid && ready
//   pix     | out | pixel_offset, pixel_color, last_pixel  | valid && ready
//   cfg     | in  | index, data (width, format)            | valid && ready
//
// One request beat per cycle while req.ready is high; a tick beat shows up on pix in the cycle after it is taken.
// The load path (stride times row multiply plus add) sets the cycle time.
// req.ready drops only while a pixel beat waits in the output register.
// Reset: no line active, width 640, grey format; cfg is always ready.
`default_nettype none

module bresenham_line_address_generator
  import blag_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  blag_req_if.sink    req,
  blag_pix_if.source  pix,
  blag_cfg_if.sink    cfg
);

  // Configuration registers
  logic [WIDTH_BITS-1:0] image_width;
  logic                  pixel_format;

  // Line state
  logic                       line_active;
  logic signed [ERR_BITS-1:0] error_term;
  logic [DELTA_BITS-1:0]      major_delta;
  logic [DELTA_BITS-1:0]      minor_delta;
  logic [OFS_BITS-1:0]        current_offset;
  logic [OFS_BITS-1:0]        major_step;
  logic [OFS_BITS-1:0]        minor_step;
  logic [DELTA_BITS-1:0]      pixels_left;
  logic [COLOR_BITS-1:0]      line_color;

  // Output register
  logic                  out_valid;
  logic [OFS_BITS-1:0]   out_offset;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  line_setup_t setup;

  logic                       req_fire;
  logic                       load_fire;
  logic                       tick_fire;
  logic signed [ERR_BITS:0]   err_sub;
  logic signed [ERR_BITS:0]   err_fix;
  logic [OFS_BITS-1:0]        ofs_major;
  logic [OFS_BITS-1:0]        offset_next;
  logic signed [ERR_BITS-1:0] error_next;
  logic [DELTA_BITS-1:0]      left_next;

  blag_setup u_setup (
    .x_start      (req.x_start),
    .y_start      (req.y_start),
    .x_end        (req.x_end),
    .y_end        (req.y_end),
    .pixel_value  (req.pixel_value),
    .image_width  (image_width),
    .pixel_format (pixel_format),
    .setup        (setup)
  );

  // Handshakes
  assign req.ready = !out_valid || pix.ready;
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign load_fire = req_fire && (req.req_type == REQ_LOAD);
  assign tick_fire = req_fire && (req.req_type == REQ_TICK) && line_active;

  // Step along the major axis, take a minor step when the error goes negative
  assign err_sub     = {error_term[ERR_BITS-1], error_term} - $signed({2'b00, minor_delta});
  assign err_fix     = err_sub + $signed({2'b00, major_delta});
  assign ofs_major   = current_offset + major_step;
  assign offset_next = (err_sub < 0) ? (ofs_major + minor_step) : ofs_major;
  assign error_next  = (err_sub < 0) ? err_fix[ERR_BITS-1:0] : err_sub[ERR_BITS-1:0];
  assign left_next   = pixels_left - DELTA_BITS'(1);

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      pixel_format <= FMT_GREY;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[WIDTH_BITS-1:0];
        CFG_PIXEL_FORMAT: pixel_format <= cfg.data[0];
        default:          ;
      endcase
    end
  end

  // Line state: load replaces the line, tick advances it
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active    <= 1'b0;
      error_term     <= '0;
      major_delta    <= '0;
      minor_delta    <= '0;
      current_offset <= '0;
      major_step     <= '0;
      minor_step     <= '0;
      pixels_left    <= '0;
      line_color     <= '0;
    end else if (load_fire) begin
      line_active    <= setup.line_active;
      error_term     <= setup.error_term;
      major_delta    <= setup.major_delta;
      minor_delta    <= setup.minor_delta;
      current_offset <= setup.start_offset;
      major_step     <= setup.major_step;
      minor_step     <= setup.minor_step;
      pixels_left    <= setup.pixels_left;
      line_color     <= setup.line_color;
    end else if (tick_fire) begin
      line_active    <= (left_next != '0);
      error_term     <= error_next;
      current_offset <= offset_next;
      pixels_left    <= left_next;
    end
  end

  // Output register: hold a pixel beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_offset <= current_offset;
      out_color  <= line_color;
      out_last   <= (pixels_left == DELTA_BITS'(1));
    end
  end

  assign pix.valid        = out_valid;
  assign pix.pixel_offset = out_offset;
  assign pix.pixel_color  = out_color;
  assign pix.last_pixel   = out_last;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for the Bresenham line address generator: line model, checker and stimulus.
module tb_top;
  import blag_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [OFS_BITS-1:0]      ofs_t;
  typedef logic [COLOR_BITS-1:0]    color_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  typedef struct packed {
    ofs_t   offset;
    color_t color;
    logic   last;
  } pixel_beat_t;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

  localparam int     COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     LONG_HOLD     = 300;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam longint TIMEOUT_NS    = 5000000;

  logic clk;
  logic rst;

  blag_req_if req_bus ();
  blag_pix_if pix_bus ();
  blag_cfg_if cfg_bus ();

  bresenham_line_address_generator dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .pix (pix_bus),
    .cfg (cfg_bus)
  );

  // Pixel beats the line engine owes us, oldest first
  pixel_beat_t pending_pixels[$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          src_idle_pct   = 0;
  int          stall_pct      = 0;
  logic        hold_req       = 1'b0;

  // Shadow of the configuration registers
  logic [WIDTH_BITS-1:0] width_shadow;
  logic                  format_shadow;

  // Shadow of the line being walked
  bit     line_on;
  int     err_acc;
  int     major_len;
  int     minor_len;
  ofs_t   walk_offset;
  ofs_t   major_inc;
  ofs_t   minor_inc;
  int     steps_left;
  color_t walk_color;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Line setup on a load beat, one pixel per tick beat while a line is open
  function automatic void rasterize_beat(input logic rtype, input coord_t xa, input coord_t ya,
                                         input coord_t xb, input coord_t yb,
                                         input color_t value);
    int          bpp;
    int          stride;
    int          adx;
    int          ady;
    ofs_t        x_inc;
    ofs_t        y_inc;
    longint      start;
    pixel_beat_t beat;
    if (rtype == REQ_LOAD) begin
      bpp    = (format_shadow == FMT_RGB) ? 3 : 1;
      stride = int'(width_shadow) * bpp;
      x_inc  = (xb >= xa) ? ofs_t'(bpp) : ofs_t'(-bpp);
      y_inc  = (yb >= ya) ? ofs_t'(stride) : ofs_t'(-stride);
      adx    = (xb >= xa) ? int'(xb) - int'(xa) : int'(xa) - int'(xb);
      ady    = (yb >= ya) ? int'(yb) - int'(ya) : int'(ya) - int'(yb);
      if (adx >= ady) begin
        major_len  = adx + 1;
        minor_len  = ady + 1;
        major_inc  = x_inc;
        minor_inc  = y_inc;
        steps_left = adx;
      end else begin
        major_len  = ady + 1;
        minor_len  = adx + 1;
        major_inc  = y_inc;
        minor_inc  = x_inc;
        steps_left = ady;
      end
      err_acc     = major_len - minor_len / 2;
      start       = longint'(bpp) * longint'(xa) + longint'(stride) * longint'(ya);
      walk_offset = ofs_t'(start);
      walk_color  = (format_shadow == FMT_RGB) ? value : color_t'(value[GREY_BITS-1:0]);
      line_on     = (steps_left != 0);
    end else if (line_on) begin
      beat.offset = walk_offset;
      beat.color  = walk_color;
      beat.last   = (steps_left == 1);
      pending_pixels.push_back(beat);
      walk_offset = walk_offset + major_inc;
      err_acc     = err_acc - minor_len;
      if (err_acc < 0) begin
        err_acc     = err_acc + major_len;
        walk_offset = walk_offset + minor_inc;
      end
      steps_left = steps_left - 1;
      line_on    = (steps_left != 0);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted pixel beat with the oldest expectation
  always @(posedge clk) begin : pixel_checker
    pixel_beat_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, got offset %h color %h last %b",
                 $time, pix_bus.pixel_offset, pix_bus.pixel_color, pix_bus.last_pixel);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_offset", 32'(want.offset), 32'(pix_bus.pixel_offset));
        check_field("pixel_color", 32'(want.color), 32'(pix_bus.pixel_color));
        check_field("last_pixel", 32'(want.last), 32'(pix_bus.last_pixel));
      end
    end
  end

  // Drive the receiver: random stalls, plus a long hold-off when requested
  initial begin : pixel_receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        pix_bus.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request beat and wait for it to be taken
  task automatic send_request(input logic rtype, input coord_t xa, input coord_t ya,
                              input coord_t xb, input coord_t yb, input color_t value);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= rtype;
    req_bus.x_start     <= xa;
    req_bus.y_start     <= ya;
    req_bus.x_end       <= xb;
    req_bus.y_end       <= yb;
    req_bus.pixel_value <= value;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    rasterize_beat(rtype, xa, ya, xb, yb, value);
    items_sent++;
  endtask

  task automatic send_load(input coord_t xa, input coord_t ya, input coord_t xb,
                           input coord_t yb, input color_t value);
    send_request(REQ_LOAD, xa, ya, xb, yb, value);
  endtask

  // Tick beats carry random junk in the unused fields
  task automatic send_tick();
    send_request(REQ_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), color_t'($urandom));
  endtask

  // Drop valid, let every owed beat arrive, then let the engine settle
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input cfg_data_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) width_shadow = value;
    else if (idx == CFG_PIXEL_FORMAT) format_shadow = value[0];
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t pick_end(input coord_t from, input int span);
    int d;
    int e;
    d = int'($urandom_range(2 * span)) - span;
    e = int'(from) + d;
    if (e < 0 || e > COORD_MAX) e = int'(from) - d;
    if (e < 0) e = 0;
    if (e > COORD_MAX) e = COORD_MAX;
    return coord_t'(e);
  endfunction

  // One load with random content, then mostly the exact number of ticks
  task automatic send_random_line();
    int     sel;
    int     span;
    int     n_ticks;
    coord_t xa;
    coord_t ya;
    sel  = $urandom_range(99);
    span = (sel < 80) ? 12 : (sel < 95) ? 200 : COORD_MAX;
    xa   = coord_t'($urandom_range(COORD_MAX));
    ya   = coord_t'($urandom_range(COORD_MAX));
    send_load(xa, ya, pick_end(xa, span), pick_end(ya, span), color_t'($urandom));
    n_ticks = steps_left;
    sel     = $urandom_range(99);
    if (sel < 15) n_ticks = $urandom_range(n_ticks);
    else if (sel < 30) n_ticks = n_ticks + $urandom_range(1, 3);
    if (n_ticks > 40) n_ticks = $urandom_range(5, 40);
    repeat (n_ticks) send_tick();
  endtask

  // Well-formed lines with some stray ticks and zero-length loads mixed in
  task automatic send_random_traffic(input int n_items);
    int     stop_at;
    int     sel;
    coord_t xa;
    coord_t ya;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_tick();
      end else if (sel < 12) begin
        xa = coord_t'($urandom);
        ya = coord_t'($urandom);
        send_load(xa, ya, xa, ya, color_t'($urandom));
        send_tick();
      end else begin
        send_random_line();
      end
    end
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    stall_pct <= sink_pct;
  endtask

  // Extremes, replaced lines, zero-length line and idle ticks at reset settings
  task automatic test_directed();
    set_idling(0, 0);
    send_tick();
    send_load(11'd2047, 11'd0, 11'd2047, 11'd0, 24'hFFFFFF);
    send_tick();
    send_load(11'd0, 11'd0, 11'd4, 11'd1, 24'h123456);
    repeat (4) send_tick();
    send_tick();
    send_load(11'd3, 11'd0, 11'd1, 11'd5, 24'h000000);
    repeat (5) send_tick();
    send_load(11'd2047, 11'd2047, 11'd0, 11'd0, 24'hFFFFFF);
    repeat (3) send_tick();
    send_load(11'd0, 11'd2047, 11'd2047, 11'd2046, 24'hA5A5A5);
    repeat (2) send_tick();
    send_load(11'd2047, 11'd0, 11'd0, 11'd2047, 24'h5A5A5A);
    send_tick();
  endtask

  // Walk through widths and formats, extremes and spare indexes included
  task automatic test_config_sweep();
    cfg_data_t widths[6];
    cfg_data_t formats[6];
    widths  = '{12'd1, 12'hFFF, 12'd0, 12'd2048, 12'h555, 12'hAAA};
    formats = '{12'h001, 12'hFFF, 12'hFFE, 12'h000, 12'h001, 12'h554};
    for (int i = 0; i < 6; i++) begin
      case (i % 4)
        0: set_idling(0, 0);
        1: set_idling(62, 0);
        2: set_idling(0, 62);
        default: set_idling(19, 19);
      endcase
      wait_drained();
      write_register(CFG_IMAGE_WIDTH, widths[i]);
      write_register(CFG_PIXEL_FORMAT, formats[i]);
      write_register((i % 2 == 0) ? CFG_SPARE_2 : CFG_SPARE_3, cfg_data_t'($urandom));
      send_random_traffic(35);
    end
  endtask

  // Hold the receiver off while ticks keep coming, so the input backs up
  task automatic test_output_hold();
    set_idling(0, 0);
    wait_drained();
    write_register(CFG_IMAGE_WIDTH, 12'd1920);
    write_register(CFG_PIXEL_FORMAT, cfg_data_t'(FMT_RGB));
    hold_req <= ~hold_req;
    send_load(11'd5, 11'd900, 11'd1500, 11'd1200, color_t'($urandom));
    repeat (60) send_tick();
  endtask

  // Pause mid-line, rewrite the registers, and check the line keeps its stride
  task automatic test_relatch_after_pause();
    set_idling(19, 19);
    wait_drained();
    write_register(CFG_IMAGE_WIDTH, 12'd100);
    write_register(CFG_PIXEL_FORMAT, cfg_data_t'(FMT_RGB));
    send_load(11'd10, 11'd20, 11'd60, 11'd45, color_t'($urandom));
    repeat (12) send_tick();
    wait_drained();
    write_register(CFG_IMAGE_WIDTH, 12'd7);
    write_register(CFG_PIXEL_FORMAT, cfg_data_t'(FMT_GREY));
    repeat (12) send_tick();
    send_load(11'd30, 11'd40, 11'd24, 11'd20, color_t'($urandom));
    repeat (20) send_tick();
  endtask

  task automatic test_random_phases();
    wait_drained();
    write_register(CFG_IMAGE_WIDTH, IMAGE_WIDTH_RESET);
    set_idling(0, 0);
    send_random_traffic(70);
    set_idling(62, 0);
    send_random_traffic(70);
    set_idling(0, 62);
    send_random_traffic(70);
    set_idling(19, 19);
    send_random_traffic(70);
  endtask

  initial begin : run_tests
    int waited;
    width_shadow  = IMAGE_WIDTH_RESET;
    format_shadow = FMT_GREY;
    line_on       = 1'b0;
    steps_left    = 0;
    rst                 <= 1'b1;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_LOAD;
    req_bus.x_start     <= '0;
    req_bus.y_start     <= '0;
    req_bus.x_end       <= '0;
    req_bus.y_end       <= '0;
    req_bus.pixel_value <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_IMAGE_WIDTH;
    cfg_bus.data        <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_sweep();
    test_output_hold();
    test_relatch_after_pause();
    test_random_phases();

    // Drain what is still owed, within a bound
    req_bus.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d pixel beats never arrived", $time, pending_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
